/* design/gfla_pkg.sv */
// Shared constants for the grouped free-list block allocator.
package gfla_pkg;

   localparam int TOTAL_BLOCKS_DEFAULT   = 1024;
   localparam int SLOTS_PER_NODE_DEFAULT = 16;

   localparam int BLK_W  = 10;
   localparam int MODE_W = 2;
   localparam int ST_W   = 2;

   localparam logic [BLK_W-1:0] RESERVED_RESET = 10'd16;

   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

/* design/grouped_free_list_block_allocator_core.sv */
// Grouped free-list block allocator: node store memory, head pointer and sequencer.
//
// One item is taken at a time. Each works through the node slots that it touches,
// reading through the single read port of the node store (one slot per cycle, read
// data registered), and then posts its result from the output state: allocate on
// an empty list reports empty straight away and otherwise scans the head node;
// free rejects a block out of range straight away, otherwise clears every slot of
// the freed block and, unless the list is empty, searches the head node; format
// writes every slot of every node in the chain, TOTAL_BLOCKS - reserved_blocks - 1
// blocks rounded up to whole nodes. The result waits in an output register, so the
// next item is taken as soon as the sequencer is idle again. The node store is not
// cleared after reset; format must run before the list is used.
module grouped_free_list_block_allocator_core #(
   parameter int TOTAL_BLOCKS   = gfla_pkg::TOTAL_BLOCKS_DEFAULT,
   parameter int SLOTS_PER_NODE = gfla_pkg::SLOTS_PER_NODE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [9:0] block_number, rest zero
   input  logic [1:0]  req_tuser,  // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [9:0] allocated_block, [11:10] status, rest zero
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);

   localparam int NODE_W    = $clog2(TOTAL_BLOCKS);
   localparam int SLOT_W    = $clog2(SLOTS_PER_NODE);
   localparam int ADDR_W    = NODE_W + SLOT_W;
   localparam int MEM_DEPTH = TOTAL_BLOCKS << SLOT_W;
   localparam int SUM_W     = $clog2(TOTAL_BLOCKS + SLOTS_PER_NODE + 1);
   localparam int CMP_W     = (SUM_W > gfla_pkg::BLK_W + 1) ? SUM_W : gfla_pkg::BLK_W + 1;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS_PER_NODE - 1);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] LINK_SLOT  = '0;
   localparam logic [CMP_W-1:0]  TOTAL_C    = CMP_W'(TOTAL_BLOCKS);
   localparam logic [CMP_W-1:0]  SLOTS_C    = CMP_W'(SLOTS_PER_NODE);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_LINK  = 3'd3;
   localparam logic [2:0] S_FMT   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [NODE_W-1:0] mem [0:MEM_DEPTH-1];

   logic [2:0]                        state_ff, state_in;
   logic [NODE_W-1:0]                 head_ff, head_in;
   logic [gfla_pkg::BLK_W-1:0]        reserved_ff, reserved_in;
   logic [gfla_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [NODE_W-1:0]                 blk_ff, blk_in;
   logic [SLOT_W-1:0]                 iss_slot_ff, iss_slot_in;
   logic [SLOT_W-1:0]                 chk_slot_ff, chk_slot_in;
   logic                              pending_ff, pending_in;
   logic [CMP_W-1:0]                  cur_ff, cur_in;
   logic [gfla_pkg::BLK_W-1:0]        res_blk_ff, res_blk_in;
   logic [gfla_pkg::ST_W-1:0]         res_st_ff, res_st_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [gfla_pkg::BLK_W-1:0]        rsp_blk_ff, rsp_blk_in;
   logic [gfla_pkg::ST_W-1:0]         rsp_st_ff, rsp_st_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [NODE_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [NODE_W-1:0] mem_wdata;

   logic [gfla_pkg::BLK_W-1:0]  req_blk;
   logic [gfla_pkg::MODE_W-1:0] req_mode;
   logic [CMP_W-1:0]            req_blk_ext;
   logic [CMP_W-1:0]            fmt_first;
   logic [CMP_W-1:0]            fmt_id;
   logic [CMP_W-1:0]            cur_next;
   logic                        scan_hit;
   logic                        req_fire;

   assign req_blk     = req_tdata[gfla_pkg::BLK_W-1:0];
   assign req_mode    = req_tuser;
   assign req_blk_ext = CMP_W'(req_blk);
   assign fmt_first   = CMP_W'(reserved_ff) + CMP_W'(1);
   assign fmt_id      = cur_ff + ((iss_slot_ff == LINK_SLOT) ? SLOTS_C : CMP_W'(iss_slot_ff));
   assign cur_next    = cur_ff + SLOTS_C;
   assign scan_hit    = (mode_ff == gfla_pkg::MODE_ALLOC) ? (rd_data_ff != '0)
                                                           : (rd_data_ff == '0);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_st_ff, rsp_blk_ff};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      reserved_in  = csr_we ? csr_wdata : reserved_ff;
      mode_in      = mode_ff;
      blk_in       = blk_ff;
      iss_slot_in  = iss_slot_ff;
      chk_slot_in  = chk_slot_ff;
      pending_in   = pending_ff;
      cur_in       = cur_ff;
      res_blk_in   = res_blk_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_blk_in   = rsp_blk_ff;
      rsp_st_in    = rsp_st_ff;
      rd_addr      = {head_ff, iss_slot_ff};
      mem_we       = 1'b0;
      mem_waddr    = {head_ff, chk_slot_ff};
      mem_wdata    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in     = req_mode;
               blk_in      = NODE_W'(req_blk);
               res_blk_in  = '0;
               res_st_in   = gfla_pkg::ST_OK;
               iss_slot_in = FIRST_SLOT;
               pending_in  = 1'b0;
               state_in    = S_OUT;
               case (req_mode)
                  gfla_pkg::MODE_ALLOC: begin
                     if (head_ff == '0) begin
                        res_st_in = gfla_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  gfla_pkg::MODE_FREE: begin
                     if (req_blk_ext <= CMP_W'(reserved_ff) || req_blk_ext >= TOTAL_C) begin
                        res_st_in = gfla_pkg::ST_RANGE;
                     end else begin
                        iss_slot_in = LINK_SLOT;
                        state_in    = S_CLEAR;
                     end
                  end
                  gfla_pkg::MODE_FORMAT: begin
                     if (fmt_first >= TOTAL_C) begin
                        head_in = '0;
                     end else begin
                        head_in     = NODE_W'(fmt_first);
                        cur_in      = fmt_first;
                        iss_slot_in = LINK_SLOT;
                        state_in    = S_FMT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = {blk_ff, iss_slot_ff};
            mem_wdata = '0;
            if (iss_slot_ff == LAST_SLOT) begin
               iss_slot_in = FIRST_SLOT;
               if (head_ff == '0) begin
                  head_in  = blk_ff;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               iss_slot_in = iss_slot_ff + SLOT_W'(1);
            end
         end
         S_SCAN: begin
            // Reads are issued one slot a cycle; the slot read last cycle is checked now.
            iss_slot_in = (iss_slot_ff == LAST_SLOT) ? iss_slot_ff : iss_slot_ff + SLOT_W'(1);
            chk_slot_in = iss_slot_ff;
            pending_in  = 1'b1;
            if (pending_ff) begin
               if (scan_hit) begin
                  mem_we    = 1'b1;
                  mem_waddr = {head_ff, chk_slot_ff};
                  if (mode_ff == gfla_pkg::MODE_ALLOC) begin
                     mem_wdata  = '0;
                     res_blk_in = gfla_pkg::BLK_W'(rd_data_ff);
                  end else begin
                     mem_wdata = blk_ff;
                  end
                  state_in = S_OUT;
               end else if (chk_slot_ff == LAST_SLOT) begin
                  if (mode_ff == gfla_pkg::MODE_ALLOC) begin
                     // Head node has no filled slots: hand out the node itself.
                     rd_addr  = {head_ff, LINK_SLOT};
                     state_in = S_LINK;
                  end else begin
                     // Head node is full: the freed block becomes the new head.
                     mem_we    = 1'b1;
                     mem_waddr = {blk_ff, LINK_SLOT};
                     mem_wdata = head_ff;
                     head_in   = blk_ff;
                     state_in  = S_OUT;
                  end
               end
            end
         end
         S_LINK: begin
            mem_we     = 1'b1;
            mem_waddr  = {head_ff, LINK_SLOT};
            mem_wdata  = '0;
            head_in    = rd_data_ff;
            res_blk_in = gfla_pkg::BLK_W'(head_ff);
            state_in   = S_OUT;
         end
         S_FMT: begin
            mem_we    = 1'b1;
            mem_waddr = {cur_ff[NODE_W-1:0], iss_slot_ff};
            mem_wdata = (fmt_id < TOTAL_C) ? NODE_W'(fmt_id) : '0;
            if (iss_slot_ff == LAST_SLOT) begin
               iss_slot_in = LINK_SLOT;
               cur_in      = cur_next;
               if (cur_next >= TOTAL_C) begin
                  state_in = S_OUT;
               end
            end else begin
               iss_slot_in = iss_slot_ff + SLOT_W'(1);
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_blk_in   = res_blk_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         reserved_ff  <= gfla_pkg::RESERVED_RESET;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         reserved_ff  <= reserved_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      blk_ff      <= blk_in;
      iss_slot_ff <= iss_slot_in;
      chk_slot_ff <= chk_slot_in;
      cur_ff      <= cur_in;
      res_blk_ff  <= res_blk_in;
      res_st_ff   <= res_st_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // An accepted item always leaves the idle state.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking an item");

   // The node store is never written while the sequencer is idle.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_we)
      else $error("node store written while idle");

   // A new result appears only out of the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result posted outside the output state");

   // The checked slot never runs ahead of the issued slot during a scan.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && pending_ff) |-> chk_slot_ff <= iss_slot_ff)
      else $error("scan check slot ahead of read slot");

endmodule

/* test/grouped_free_list_block_allocator_core_tb.sv */
// Self-checking testbench for the grouped free-list block allocator core.
module grouped_free_list_block_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL = gfla_pkg::TOTAL_BLOCKS_DEFAULT;
   localparam int SLOTS = gfla_pkg::SLOTS_PER_NODE_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 156;

   typedef logic [gfla_pkg::BLK_W-1:0]  blk_type;
   typedef logic [gfla_pkg::MODE_W-1:0] mode_type;
   typedef struct packed {
      blk_type                   block;
      logic [gfla_pkg::ST_W-1:0] status;
   } alloc_result_type;

   localparam mode_type MODE_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // [9:0] block_number, rest zero
   logic [1:0]  req_tuser = '0;  // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // [9:0] allocated_block, [11:10] status, rest zero
   logic        csr_we = 1'b0;
   logic [9:0]  csr_wdata = '0;

   // Shadow copy of the allocator state, updated as each item is accepted.
   blk_type node_image [TOTAL][SLOTS] = '{default: '0};
   blk_type head_image = '0;
   blk_type reserved_image = gfla_pkg::RESERVED_RESET;

   alloc_result_type pending_results[$];
   blk_type          blocks_in_use[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int formats_sent = 0;
   int grants_seen = 0;
   int empty_seen = 0;
   int range_seen = 0;
   int reserved_writes = 0;

   grouped_free_list_block_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic alloc_result_type predict_allocator(input mode_type mode,
                                                          input blk_type blk);
      alloc_result_type r;
      blk_type h;
      int s;
      int cur;
      int id;
      bit done;
      r.block = '0;
      r.status = gfla_pkg::ST_OK;
      done = 1'b0;
      case (mode)
         gfla_pkg::MODE_ALLOC: begin
            h = head_image;
            if (h == '0) begin
               r.status = gfla_pkg::ST_EMPTY;
            end else begin
               for (s = 1; s < SLOTS && !done; s++) begin
                  if (node_image[h][s] != '0) begin
                     r.block = node_image[h][s];
                     node_image[h][s] = '0;
                     done = 1'b1;
                  end
               end
               // With its slots used up, the head node itself is handed out.
               if (!done) begin
                  head_image = node_image[h][0];
                  node_image[h][0] = '0;
                  r.block = h;
               end
            end
         end
         gfla_pkg::MODE_FREE: begin
            if (blk <= reserved_image || int'(blk) >= TOTAL) begin
               r.status = gfla_pkg::ST_RANGE;
            end else begin
               for (s = 0; s < SLOTS; s++) node_image[blk][s] = '0;
               if (head_image == '0) begin
                  head_image = blk;
               end else begin
                  h = head_image;
                  for (s = 1; s < SLOTS && !done; s++) begin
                     if (node_image[h][s] == '0) begin
                        node_image[h][s] = blk;
                        done = 1'b1;
                     end
                  end
                  if (!done) begin
                     head_image = blk;
                     node_image[blk][0] = h;
                  end
               end
            end
         end
         gfla_pkg::MODE_FORMAT: begin
            cur = int'(reserved_image) + 1;
            if (cur >= TOTAL) begin
               head_image = '0;
            end else begin
               head_image = blk_type'(cur);
               while (cur < TOTAL) begin
                  id = cur;
                  for (s = 1; s < SLOTS; s++) begin
                     id++;
                     node_image[cur][s] = (id < TOTAL) ? blk_type'(id) : '0;
                  end
                  id++;
                  node_image[cur][0] = (id < TOTAL) ? blk_type'(id) : '0;
                  cur = id;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input mode_type mode, input blk_type blk);
      alloc_result_type exp;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {6'd0, blk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp = predict_allocator(mode, blk);
      pending_results.push_back(exp);
      items_sent++;
      if (mode == gfla_pkg::MODE_FORMAT) begin
         formats_sent++;
         blocks_in_use.delete();
      end
      if (mode == gfla_pkg::MODE_ALLOC && exp.status == gfla_pkg::ST_OK) begin
         blocks_in_use.push_back(exp.block);
         grants_seen++;
      end
      if (exp.status == gfla_pkg::ST_EMPTY) empty_seen++;
      if (exp.status == gfla_pkg::ST_RANGE) range_seen++;
   endtask

   // Valid is left high after an accepted item; this lowers it and waits for the
   // block to hand back everything that is still owed.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reserved(input blk_type value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      reserved_image = value;
      reserved_writes++;
   endtask

   task automatic test_before_format();
      send_item(gfla_pkg::MODE_ALLOC, 10'h3FF);
      send_item(gfla_pkg::MODE_FREE, 10'd0);
      send_item(gfla_pkg::MODE_FREE, gfla_pkg::RESERVED_RESET);
      send_item(gfla_pkg::MODE_FREE, gfla_pkg::RESERVED_RESET + 10'd1);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(MODE_UNUSED, 10'h3FF);
   endtask

   task automatic test_list_shapes();
      write_reserved(gfla_pkg::RESERVED_RESET);
      send_item(gfla_pkg::MODE_FORMAT, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_FREE, 10'd1023);
      // The head node is now full, so this block becomes the new head.
      send_item(gfla_pkg::MODE_FREE, 10'd18);
      // Freeing the head again clears it and files it in its own first slot.
      send_item(gfla_pkg::MODE_FREE, 10'd18);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
   endtask

   task automatic test_reserved_extremes();
      write_reserved(10'd1022);
      send_item(gfla_pkg::MODE_FORMAT, 10'h3FF);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      send_item(gfla_pkg::MODE_FREE, 10'd1022);
      send_item(gfla_pkg::MODE_FREE, 10'd1023);
      // No data blocks at all: format leaves the list empty.
      write_reserved(10'd1023);
      send_item(gfla_pkg::MODE_FORMAT, 10'd0);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
      write_reserved(10'd1);
      send_item(gfla_pkg::MODE_FORMAT, 10'd0);
      send_item(gfla_pkg::MODE_FREE, 10'd1);
      send_item(gfla_pkg::MODE_ALLOC, 10'd0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input blk_type reserved, input bit hold_off);
      int i;
      int pick;
      int idx;
      blk_type b;
      write_reserved(reserved);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      send_item(gfla_pkg::MODE_FORMAT, blk_type'($urandom));
      for (i = 0; i < PHASE_ITEMS; i++) begin
         if (hold_off && i == 20) rsp_hold_cycles = 300;
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_item(gfla_pkg::MODE_ALLOC, blk_type'($urandom));
         end else if (pick < 80 && blocks_in_use.size() != 0) begin
            idx = $urandom_range(blocks_in_use.size() - 1);
            b = blocks_in_use[idx];
            blocks_in_use.delete(idx);
            send_item(gfla_pkg::MODE_FREE, b);
         end else if (pick < 95) begin
            send_item(gfla_pkg::MODE_FREE, blk_type'($urandom_range(1023)));
         end else if (pick < 98) begin
            send_item(MODE_UNUSED, blk_type'($urandom));
         end else begin
            send_item(gfla_pkg::MODE_FORMAT, blk_type'($urandom));
         end
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   alloc_result_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result item with none expected: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[9:0] !== oldest.block) begin
               $error("allocated_block: expected %0d, got %0d", oldest.block, rsp_tdata[9:0]);
               error_count++;
            end
            if (rsp_tdata[11:10] !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_tdata[11:10]);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_format();
      test_list_shapes();
      test_reserved_extremes();
      test_random_traffic(0, 0, 10'd1000, 1'b1);
      test_random_traffic(79, 0, blk_type'($urandom_range(1, 1022)), 1'b0);
      test_random_traffic(0, 79, 10'd0, 1'b0);
      test_random_traffic(7, 7, blk_type'($urandom_range(900, 1010)), 1'b0);

      drain_results();
      repeat (64) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected result items never arrived", pending_results.size());
         error_count++;
      end

      $display("Sent %0d items (%0d formats) across %0d reserved-count settings",
               items_sent, formats_sent, reserved_writes);
      $display("and four idling mixes: %0d granted, %0d empty replies, %0d rejections.",
               grants_seen, empty_seen, range_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
